// ===== design/ffesc_pkg.sv =====
// ============================================================================
// ffesc_pkg
// Shared types and constants for the FF escape decoder: item layouts,
// status codes, decoder phases and the command passed from front to back.
// ============================================================================
package ffesc_pkg;

    // Length of the plain run opened by a zero code byte
    localparam int unsigned RUN_LENGTH = 252;

    // Default depth of the command queue between front and back
    localparam int unsigned CMD_DEPTH_DEF = 4;

    // Byte values with special meaning
    localparam logic [7:0] BYTE_ESC     = 8'hFF;
    localparam logic [7:0] BYTE_BAD_FD  = 8'hFD;
    localparam logic [7:0] BYTE_BAD_FE  = 8'hFE;
    localparam logic [7:0] CODE_RUN     = 8'h00;
    localparam logic [7:0] CODE_DOUBLE  = 8'h01;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CODE  = 3'd1,
        ST_RUN   = 3'd2,
        ST_SPAN  = 3'd3,
        ST_TRUNC = 3'd4
    } status_t;

    // Decoder phase, one-hot
    typedef enum logic [4:0] {
        PH_PLAIN = 5'b00001,
        PH_CODE  = 5'b00010,
        PH_RUN   = 5'b00100,
        PH_SPAN  = 5'b01000,
        PH_DROP  = 5'b10000
    } phase_t;

    // One encoded input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } in_item_t;

    // One decoded result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        status_t    status;
        logic       last;
    } out_item_t;

    // Work for the back end: up to three results, emitted in field order
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       ins_ff;
        logic       end_valid;
        status_t    end_status;
    } cmd_t;

endpackage

// ===== design/ffesc_front.sv =====
// ============================================================================
// ffesc_front
// Accepts encoded items, tracks the escape phase and turns each item into a
// command naming the results it causes.
// ============================================================================
module ffesc_front
    import ffesc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output logic     cmd_push,
    output cmd_t     cmd
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] span_count_reg;
    logic [7:0] span_count_next;

    logic       err;
    status_t    err_status;
    logic [7:0] span_dec;
    logic [8:0] run_inc;

    assign span_dec = (span_count_reg != 8'd0) ? (span_count_reg - 8'd1) : 8'd0;
    assign run_inc  = {1'b0, span_count_reg} + 9'd1;

    // Classify the item against the current phase
    always_comb
    begin
        phase_next      = phase_reg;
        span_count_next = span_count_reg;
        err             = 1'b0;
        err_status      = ST_OK;
        cmd             = '0;
        cmd.data_byte   = item.in_byte;
        cmd.end_status  = ST_OK;

        unique case (phase_reg)
            PH_PLAIN:
            begin
                cmd.data_valid = 1'b1;
                if (item.in_byte == BYTE_ESC)
                begin
                    phase_next = PH_CODE;
                end
            end
            PH_CODE:
            begin
                if (item.in_byte == BYTE_BAD_FD || item.in_byte == BYTE_BAD_FE ||
                    item.in_byte == BYTE_ESC)
                begin
                    err        = 1'b1;
                    err_status = ST_CODE;
                end
                else if (item.in_byte == CODE_RUN)
                begin
                    span_count_next = 8'd0;
                    phase_next      = PH_RUN;
                end
                else if (item.in_byte == CODE_DOUBLE)
                begin
                    cmd.data_valid = 1'b1;
                    cmd.data_byte  = BYTE_ESC;
                    phase_next     = PH_PLAIN;
                end
                else
                begin
                    span_count_next = item.in_byte - 8'd1;
                    phase_next      = PH_SPAN;
                end
            end
            PH_RUN:
            begin
                if (item.in_byte == BYTE_ESC)
                begin
                    err        = 1'b1;
                    err_status = ST_RUN;
                end
                else
                begin
                    cmd.data_valid  = 1'b1;
                    span_count_next = run_inc[7:0];
                    if (run_inc >= 9'(RUN_LENGTH))
                    begin
                        span_count_next = 8'd0;
                        phase_next      = PH_PLAIN;
                    end
                end
            end
            PH_SPAN:
            begin
                if (item.in_byte == BYTE_ESC)
                begin
                    err        = 1'b1;
                    err_status = ST_SPAN;
                end
                else
                begin
                    cmd.data_valid  = 1'b1;
                    span_count_next = span_dec;
                    if (span_dec == 8'd0)
                    begin
                        cmd.ins_ff = 1'b1;
                        phase_next = PH_PLAIN;
                    end
                end
            end
            default:
            begin
                // Drop bytes until the end of the message
                if (item.end_of_message)
                begin
                    phase_next      = PH_PLAIN;
                    span_count_next = 8'd0;
                end
            end
        endcase

        if (err)
        begin
            cmd.end_valid   = 1'b1;
            cmd.end_status  = err_status;
            phase_next      = item.end_of_message ? PH_PLAIN : PH_DROP;
            span_count_next = 8'd0;
        end
        else if (item.end_of_message && phase_reg != PH_DROP &&
                 (phase_reg == PH_PLAIN || phase_reg == PH_CODE ||
                  phase_reg == PH_RUN || phase_reg == PH_SPAN))
        begin
            cmd.end_valid   = 1'b1;
            cmd.end_status  = (phase_next == PH_CODE || phase_next == PH_SPAN) ?
                              ST_TRUNC : ST_OK;
            phase_next      = PH_PLAIN;
            span_count_next = 8'd0;
        end
    end

    // Queue only items that cause at least one result
    assign cmd_push = accept && (cmd.data_valid || cmd.ins_ff || cmd.end_valid);

    // Advance phase on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PLAIN;
            span_count_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            span_count_reg <= span_count_next;
        end
    end

endmodule

// ===== design/ffesc_cmd_fifo.sv =====
// ============================================================================
// ffesc_cmd_fifo
// Short command queue that lets the front and the back stall independently.
// ============================================================================
module ffesc_cmd_fifo
    import ffesc_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output cmd_t rd_cmd,
    output logic valid
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_FULL);
    assign valid  = (count_reg != '0);
    assign rd_cmd = slots_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && valid;

    // Store incoming commands
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/ffesc_back.sv =====
// ============================================================================
// ffesc_back
// Expands each command into its result items into a registered output
// stage, one per cycle unless a held result stalls the stage.
// ============================================================================
module ffesc_back
    import ffesc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic [2:0] done_reg;
    logic [2:0] pend;
    logic [2:0] pick;
    logic       load;
    out_item_t  sel_item;
    out_item_t  out_item_reg;
    logic       out_valid_reg;

    // Results still owed by the head command: data, inserted FF, end status
    assign pend = {cmd.end_valid & ~done_reg[2],
                   cmd.ins_ff    & ~done_reg[1],
                   cmd.data_valid & ~done_reg[0]} & {3{cmd_valid}};

    // Oldest owed result first
    always_comb
    begin
        pick     = 3'b000;
        sel_item = '0;
        if (pend[0])
        begin
            pick              = 3'b001;
            sel_item.out_byte = cmd.data_byte;
            sel_item.has_byte = 1'b1;
            sel_item.status   = ST_OK;
        end
        else if (pend[1])
        begin
            pick              = 3'b010;
            sel_item.out_byte = BYTE_ESC;
            sel_item.has_byte = 1'b1;
            sel_item.status   = ST_OK;
        end
        else if (pend[2])
        begin
            pick              = 3'b100;
            sel_item.status   = cmd.end_status;
            sel_item.last     = 1'b1;
        end
        else
        begin
            sel_item.status   = ST_OK;
        end
    end

    assign load    = (pend != 3'b000) && (!out_valid_reg || pop);
    assign cmd_pop = load && ((pend & ~pick) == 3'b000);
    assign empty   = !out_valid_reg;
    assign result  = out_item_reg;

    // Track which results of the head command are already out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 3'b000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_pop)
            begin
                done_reg <= 3'b000;
            end
            else if (load)
            begin
                done_reg <= done_reg | pick;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= sel_item;
        end
    end

endmodule

// ===== design/ff_escape_decoder_core.sv =====
// ============================================================================
// ff_escape_decoder_core
// FF escape decoder: decodes an escaped byte stream into plain bytes with a
// closing status item per message.
// ============================================================================
//
//   Channel   Direction  Handshake          Payload
//   input     in         push / full        item   (in_item_t)
//   result    out        pop / empty        result (out_item_t)
//
// One encoded item is accepted per cycle while full is low; each causes zero
// to three results, which leave one per cycle through the output register
// unless a held result stalls it, so the result side bounds throughput. The
// front classifies an item in the cycle it is accepted and queues its command
// at that edge; results then pass through the queue and the output register.
// full rises while the command queue holds CMD_DEPTH entries. Reset clears
// the phase, the queue and the output stage; no clearing pass is needed.
//
module ff_escape_decoder_core
    import ffesc_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic accept;
    logic cmd_push;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic head_valid;
    logic head_pop;

    assign accept = push && !full;

    // Classify items
    ffesc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    // Decouple front from back
    ffesc_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (head_pop),
        .rd_cmd (head_cmd),
        .valid  (head_valid)
    );

    // Emit results
    ffesc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (head_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== dv/tb_ff_escape_decoder_core.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_ff_escape_decoder_core
// Self-checking bench for the FF escape decoder. A directed table covers
// the escape codes, bad codes, FF inside a run or a span and truncated
// messages. Random messages follow: mostly well-formed, some broken, some
// noise. A byte-level decoder model predicts all but typed-row results. Both
// sides idle at random, and one long receiver hold-off fills the block.
// ============================================================================
module tb_ff_escape_decoder_core;
    import ffesc_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 50;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 24;

    localparam out_item_t NO_RES = '0;

    // Directed stimulus row; typed rows carry their results inline
    typedef struct packed {
        in_item_t   it;
        logic       typed;
        logic [1:0] n;
        out_item_t  r0;
        out_item_t  r1;
        out_item_t  r2;
    } dir_row_t;

    logic      clk    = 1'b0;
    logic      rst_n  = 1'b0;
    logic      push   = 1'b0;
    logic      pop    = 1'b0;
    in_item_t  item   = '0;
    logic      full;
    logic      empty;
    out_item_t result;

    // Decoder model state
    phase_t     dec_phase = PH_PLAIN;
    logic [7:0] span_cnt  = '0;
    out_item_t  byte_results[$];

    out_item_t  decoded_q[$];
    dir_row_t   dir_table[$];
    logic [7:0] msg[$];
    int         errors       = 0;
    int         received     = 0;
    int         idle_cycles  = 0;

    ff_escape_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic out_item_t data_res(input logic [7:0] b);
        out_item_t r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.status   = ST_OK;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic out_item_t end_res(input status_t st);
        out_item_t r;
        r.out_byte = 8'h00;
        r.has_byte = 1'b0;
        r.status   = st;
        r.last     = 1'b1;
        return r;
    endfunction

    // Decode one encoded byte into byte_results and advance the model state
    function automatic void decode_byte(input in_item_t it);
        logic [7:0] b;
        logic       eom;
        logic       err;
        status_t    est;
        b   = it.in_byte;
        eom = it.end_of_message;
        err = 1'b0;
        est = ST_OK;
        byte_results.delete();
        case (dec_phase)
            PH_PLAIN:
            begin
                byte_results.push_back(data_res(b));
                if (b == BYTE_ESC)
                    dec_phase = PH_CODE;
            end
            PH_CODE:
            begin
                if (b == BYTE_BAD_FD || b == BYTE_BAD_FE || b == BYTE_ESC)
                begin
                    err = 1'b1;
                    est = ST_CODE;
                end
                else if (b == CODE_RUN)
                begin
                    span_cnt  = 8'd0;
                    dec_phase = PH_RUN;
                end
                else if (b == CODE_DOUBLE)
                begin
                    byte_results.push_back(data_res(BYTE_ESC));
                    dec_phase = PH_PLAIN;
                end
                else
                begin
                    span_cnt  = b - 8'd1;
                    dec_phase = PH_SPAN;
                end
            end
            PH_RUN:
            begin
                if (b == BYTE_ESC)
                begin
                    err = 1'b1;
                    est = ST_RUN;
                end
                else
                begin
                    span_cnt = span_cnt + 8'd1;
                    byte_results.push_back(data_res(b));
                    if (span_cnt >= RUN_LENGTH)
                    begin
                        span_cnt  = 8'd0;
                        dec_phase = PH_PLAIN;
                    end
                end
            end
            PH_SPAN:
            begin
                if (b == BYTE_ESC)
                begin
                    err = 1'b1;
                    est = ST_SPAN;
                end
                else
                begin
                    byte_results.push_back(data_res(b));
                    if (span_cnt > 8'd0)
                        span_cnt = span_cnt - 8'd1;
                    if (span_cnt == 8'd0)
                    begin
                        byte_results.push_back(data_res(BYTE_ESC));
                        dec_phase = PH_PLAIN;
                    end
                end
            end
            default:
            begin
                // Drop everything up to the end marker
                if (eom)
                begin
                    dec_phase = PH_PLAIN;
                    span_cnt  = 8'd0;
                end
                return;
            end
        endcase

        if (err)
        begin
            byte_results.push_back(end_res(est));
            dec_phase = eom ? PH_PLAIN : PH_DROP;
            span_cnt  = 8'd0;
            return;
        end

        if (eom)
        begin
            if (dec_phase == PH_CODE || dec_phase == PH_SPAN)
                byte_results.push_back(end_res(ST_TRUNC));
            else
                byte_results.push_back(end_res(ST_OK));
            dec_phase = PH_PLAIN;
            span_cnt  = 8'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        $display("%0t ns: mismatch on %s: got %02h, want %02h", $time, what, got_v, want_v);
        errors++;
    endtask

    task automatic row_pred(input logic [7:0] b, input logic eom);
        dir_row_t r;
        r          = '0;
        r.it       = '{in_byte: b, end_of_message: eom};
        r.typed    = 1'b0;
        dir_table.push_back(r);
    endtask

    task automatic row_typed(input logic [7:0] b, input logic eom, input logic [1:0] n,
                             input out_item_t r0, input out_item_t r1, input out_item_t r2);
        dir_row_t r;
        r.it    = '{in_byte: b, end_of_message: eom};
        r.typed = 1'b1;
        r.n     = n;
        r.r0    = r0;
        r.r1    = r1;
        r.r2    = r2;
        dir_table.push_back(r);
    endtask

    // Offer one item after a random gap and hold it until it is taken
    int send_burst = 0;
    task automatic send_item(input in_item_t it);
        int gap;
        if (send_burst > 0)
        begin
            gap = 0;
            send_burst--;
        end
        else
        begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
    endtask

    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    // Build one random message in msg: well-formed, broken or noise
    task automatic build_message(input bit full_run);
        int kind;
        int tokens;
        int n;
        int pos;
        bit done;
        msg.delete();
        if (full_run)
        begin
            msg.push_back(BYTE_ESC);
            msg.push_back(CODE_RUN);
            repeat (RUN_LENGTH) msg.push_back(plain_byte());
            // Back in plain phase: an FF here is an escape again
            msg.push_back(BYTE_ESC);
            msg.push_back(CODE_DOUBLE);
            msg.push_back(plain_byte());
            return;
        end
        kind = $urandom_range(0, 19);
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
            return;
        end
        tokens = $urandom_range(1, 8);
        done   = 1'b0;
        for (int t = 0; t < tokens && !done; t++)
        begin
            n = $urandom_range(0, 9);
            if (n < 4)
                msg.push_back(plain_byte());
            else if (n < 6)
            begin
                msg.push_back(BYTE_ESC);
                msg.push_back(CODE_DOUBLE);
            end
            else if (n < 9)
            begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(2, 252) : $urandom_range(2, 8);
                msg.push_back(BYTE_ESC);
                msg.push_back(8'(n));
                repeat (n - 1) msg.push_back(plain_byte());
            end
            else
            begin
                // A short run swallows the rest, so close the message here
                msg.push_back(BYTE_ESC);
                msg.push_back(CODE_RUN);
                repeat ($urandom_range(0, 12)) msg.push_back(plain_byte());
                done = 1'b1;
            end
        end
        if (kind < 5)
        begin
            pos = $urandom_range(0, msg.size() - 1);
            case ($urandom_range(0, 2))
                0: msg[pos] = 8'($urandom_range(0, 255));
                1: msg[pos] = 8'($urandom_range(8'hFD, 8'hFF));
                default:
                begin
                    while (msg.size() > pos + 1)
                        void'(msg.pop_back());
                end
            endcase
        end
    endtask

    // Stimulus: directed table, then random messages, then drain
    initial
    begin
        in_item_t it;
        int       rand_items;
        bit       first;
        rand_items = 0;

        row_typed(8'h00, 1'b0, 2'd1, data_res(8'h00), NO_RES, NO_RES);
        row_typed(8'hFF, 1'b0, 2'd1, data_res(8'hFF), NO_RES, NO_RES);
        row_typed(8'h01, 1'b0, 2'd1, data_res(8'hFF), NO_RES, NO_RES);
        row_pred (8'hFF, 1'b0);
        row_typed(8'h00, 1'b0, 2'd0, NO_RES, NO_RES, NO_RES);
        row_pred (8'h7F, 1'b0);
        row_typed(8'hFE, 1'b1, 2'd2, data_res(8'hFE), end_res(ST_OK), NO_RES);
        row_pred (8'hFF, 1'b0);
        row_typed(8'hFD, 1'b0, 2'd1, end_res(ST_CODE), NO_RES, NO_RES);
        row_typed(8'h34, 1'b1, 2'd0, NO_RES, NO_RES, NO_RES);
        row_pred (8'hFF, 1'b0);
        row_pred (8'h02, 1'b0);
        row_typed(8'hAA, 1'b1, 2'd3, data_res(8'hAA), data_res(8'hFF), end_res(ST_OK));
        row_pred (8'hFF, 1'b0);
        row_typed(8'hFE, 1'b1, 2'd1, end_res(ST_CODE), NO_RES, NO_RES);
        row_pred (8'hFF, 1'b0);
        row_typed(8'hFF, 1'b0, 2'd1, end_res(ST_CODE), NO_RES, NO_RES);
        row_typed(8'hFF, 1'b1, 2'd0, NO_RES, NO_RES, NO_RES);
        row_pred (8'hFF, 1'b0);
        row_pred (8'hFC, 1'b0);
        row_typed(8'hFF, 1'b0, 2'd1, end_res(ST_SPAN), NO_RES, NO_RES);
        row_typed(8'h55, 1'b1, 2'd0, NO_RES, NO_RES, NO_RES);
        row_pred (8'hFF, 1'b0);
        row_pred (8'h00, 1'b0);
        row_typed(8'hFF, 1'b1, 2'd1, end_res(ST_RUN), NO_RES, NO_RES);
        row_typed(8'hFF, 1'b1, 2'd2, data_res(8'hFF), end_res(ST_TRUNC), NO_RES);

        // Hold reset, then release at an edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_table[i])
        begin
            send_item(dir_table[i].it);
            decode_byte(dir_table[i].it);
            if (dir_table[i].typed)
            begin
                if (dir_table[i].n > 0) decoded_q.push_back(dir_table[i].r0);
                if (dir_table[i].n > 1) decoded_q.push_back(dir_table[i].r1);
                if (dir_table[i].n > 2) decoded_q.push_back(dir_table[i].r2);
            end
            else
            begin
                foreach (byte_results[k]) decoded_q.push_back(byte_results[k]);
            end
        end

        // Random messages; the first one carries a complete plain run
        first = 1'b1;
        while (rand_items < RANDOM_ITEMS)
        begin
            build_message(first);
            first = 1'b0;
            foreach (msg[i])
            begin
                it.in_byte        = msg[i];
                it.end_of_message = (i == msg.size() - 1);
                send_item(it);
                if (dec_phase != PH_DROP)
                    rand_items++;
                decode_byte(it);
                foreach (byte_results[k]) decoded_q.push_back(byte_results[k]);
            end
        end
        push <= 1'b0;

        // Drain: wait for every expected item, then catch any extra ones
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decoded_q.size() != 0)
            report_mismatch("missing results", 8'(decoded_q.size()), 8'h00);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, bursts, and one long hold-off
    initial
    begin
        int        stall;
        int        burst;
        bit        held;
        out_item_t got;
        out_item_t want;
        burst = 0;
        held  = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && received >= HOLD_AFTER)
            begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            else if (burst > 0)
            begin
                stall = 0;
                burst--;
            end
            else
            begin
                stall = $urandom_range(0, 8);
                if ($urandom_range(0, 19) == 0)
                    burst = $urandom_range(10, 30);
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            got = result;
            received++;
            // Compare against the oldest expectation, field by field
            if (decoded_q.size() == 0)
                report_mismatch("unexpected item", got.out_byte, 8'h00);
            else
            begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", got.out_byte, want.out_byte);
                if (got.has_byte !== want.has_byte)
                    report_mismatch("has_byte", {7'b0, got.has_byte}, {7'b0, want.has_byte});
                if (got.status !== want.status)
                    report_mismatch("status", {5'b0, got.status}, {5'b0, want.status});
                if (got.last !== want.last)
                    report_mismatch("last", {7'b0, got.last}, {7'b0, want.last});
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
